### rtl/bap_pkg.sv
package bap_pkg;

  localparam int unsigned MAX_NAME   = 32;
  localparam int unsigned MAX_RECORD = 31;

  localparam logic [7:0] TYPE_FLAGS         = 8'h01;
  localparam logic [7:0] TYPE_NAME_SHORT    = 8'h08;
  localparam logic [7:0] TYPE_NAME_COMPLETE = 8'h09;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned KIND_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 2'd0,
    KIND_FLAGS    = 2'd1,
    KIND_SHORT    = 2'd2,
    KIND_COMPLETE = 2'd3
  } kind_t;

  // one parsed result, as it waits in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [4:0] name_index;
    logic       record_end;
    logic       record_error;
  } result_t;

endpackage

### rtl/bap_front.sv
module bap_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic [4:0]        record_length,
  output bap_pkg::result_t  result
);

  typedef enum logic [1:0] {
    FT_OTHER,
    FT_FLAGS,
    FT_SHORT,
    FT_COMPLETE
  } ftype_t;

  logic [4:0] byte_offset_r, byte_offset_nxt;
  logic [4:0] field_rem_r, field_rem_nxt;
  logic [4:0] field_pos_r, field_pos_nxt;
  ftype_t     field_type_r, field_type_nxt;
  logic [4:0] rec_len_r, rec_len_nxt;
  logic       error_seen_r, error_seen_nxt;

  logic [4:0] len_c;
  logic [4:0] off;
  logic [4:0] rem;
  logic [4:0] fpos;
  ftype_t     ftype;
  logic       err;
  logic [4:0] ci;
  logic [8:0] field_end;

  always_comb begin
    len_c = ({3'b000, record_length} > 8'(bap_pkg::MAX_RECORD)) ?
            5'(bap_pkg::MAX_RECORD) : record_length;

    // a first byte restarts the walk before the byte itself is parsed
    rec_len_nxt = first_byte ? len_c : rec_len_r;
    off   = first_byte ? 5'd0 : byte_offset_r;
    rem   = first_byte ? 5'd0 : field_rem_r;
    fpos  = first_byte ? 5'd0 : field_pos_r;
    ftype = first_byte ? FT_OTHER : field_type_r;
    err   = first_byte ? 1'b0 : error_seen_r;

    byte_offset_nxt = off;
    field_rem_nxt   = rem;
    field_pos_nxt   = fpos;
    field_type_nxt  = ftype;
    error_seen_nxt  = err;

    ci        = fpos - 5'd1;
    field_end = {4'b0000, off} + {1'b0, data_byte} + 9'd1;
    result    = '0;

    if (off < rec_len_nxt) begin
      if (!err) begin
        if (rem == 5'd0) begin
          if (data_byte != 8'd0) begin
            // length byte counts toward the record
            if (field_end > {4'b0000, rec_len_nxt}) begin
              error_seen_nxt = 1'b1;
            end else begin
              field_rem_nxt = data_byte[4:0];
              field_pos_nxt = 5'd0;
            end
          end
        end else begin
          if (fpos == 5'd0) begin
            unique case (data_byte)
              bap_pkg::TYPE_FLAGS:         field_type_nxt = FT_FLAGS;
              bap_pkg::TYPE_NAME_SHORT:    field_type_nxt = FT_SHORT;
              bap_pkg::TYPE_NAME_COMPLETE: field_type_nxt = FT_COMPLETE;
              default:                     field_type_nxt = FT_OTHER;
            endcase
          end else begin
            unique case (ftype) inside
              FT_FLAGS: begin
                if (ci == 5'd0) begin
                  result.kind  = bap_pkg::KIND_FLAGS;
                  result.value = data_byte;
                end
              end
              FT_SHORT, FT_COMPLETE: begin
                if ({1'b0, ci} < 6'(bap_pkg::MAX_NAME)) begin
                  result.kind = (ftype == FT_SHORT) ? bap_pkg::KIND_SHORT :
                                                      bap_pkg::KIND_COMPLETE;
                  result.value      = data_byte;
                  result.name_index = ci;
                end
              end
              default: ;
            endcase
          end
          field_pos_nxt = fpos + 5'd1;
          field_rem_nxt = rem - 5'd1;
        end
      end
      byte_offset_nxt = off + 5'd1;
      if (off + 5'd1 == rec_len_nxt) begin
        result.record_end   = 1'b1;
        result.record_error = error_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      field_rem_r   <= '0;
      field_pos_r   <= '0;
      field_type_r  <= FT_OTHER;
      rec_len_r     <= '0;
      error_seen_r  <= 1'b0;
    end else if (accept) begin
      byte_offset_r <= byte_offset_nxt;
      field_rem_r   <= field_rem_nxt;
      field_pos_r   <= field_pos_nxt;
      field_type_r  <= field_type_nxt;
      rec_len_r     <= rec_len_nxt;
      error_seen_r  <= error_seen_nxt;
    end
  end

endmodule

### rtl/bap_queue.sv
module bap_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bap_pkg::result_t  push_data,
  output logic              full,
  output logic              head_valid,
  input  logic              pop,
  output bap_pkg::result_t  head_data
);

  bap_pkg::result_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/ble_adv_data_field_parser.sv
// channel  direction  handshake             payload
// in_      slave      in_tvalid/in_tready   tdata {record_length, data_byte}, tuser first_byte
// out_     master     out_tvalid/out_tready tdata {record_error, name_index, value},
//                                           tuser kind, tlast record_end
// Every request in gives exactly one request out; one byte per cycle sustained while out_tready is high.
// The parser updates its state on accept and writes the result into a
// two-entry queue whose head drives the output ports.
// in_tready drops only while both queue entries are occupied.
// rst_n is synchronous, active low, and clears parse state and the queue.
module ble_adv_data_field_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bap_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte, [12:8] record_length
  input  logic [0:0]                     in_tuser,   // [0] first_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bap_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] value, [12:8] name_index,
                                                     // [13] record_error
  output logic [bap_pkg::KIND_W-1:0]     out_tuser,  // [1:0] kind
  output logic                           out_tlast
);

  logic             in_accept;
  logic             q_full;
  logic             q_pop;
  bap_pkg::result_t front_result;
  bap_pkg::result_t head;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;
  assign q_pop     = out_tvalid && out_tready;

  bap_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .data_byte     (in_tdata[7:0]),
    .first_byte    (in_tuser[0]),
    .record_length (in_tdata[12:8]),
    .result        (front_result)
  );

  bap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (front_result),
    .full       (q_full),
    .head_valid (out_tvalid),
    .pop        (q_pop),
    .head_data  (head)
  );

  assign out_tdata = {2'b00, head.record_error, head.name_index, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.record_end;

endmodule

### rtl/bap_checker.sv
module bap_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bap_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bap_pkg::KIND_W-1:0]     out_tuser,
  input logic                           out_tlast
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bap_pkg::KIND_NONE |-> out_tdata[12:0] == 13'd0)
    else $error("payload set on empty result");

  a_err_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tlast && out_tuser == bap_pkg::KIND_NONE)
    else $error("error reported away from record end");

  a_flags_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bap_pkg::KIND_FLAGS |-> out_tdata[12:8] == 5'd0)
    else $error("flags result with nonzero index");

endmodule

bind ble_adv_data_field_parser bap_checker u_bap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
